[rtl/core/fbde_pkg.sv]
// fbde_pkg: shared types and constants of the monochrome frame store draw engine
// request codes, queue command layout and pixel constants; no dependencies

package fbde_pkg;

  // request codes carried in the input tuser
  typedef enum logic [1:0] {
    REQ_PLOT  = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_type_e;

  // classified work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_FILL      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_READ      = 2'd2,
    CMD_READ_ZERO = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [8:0]  xe;     // clipped exclusive right edge
    logic [8:0]  ye;     // clipped exclusive bottom edge
    logic        color;
    logic [12:0] addr;
    logic [7:0]  value;
  } cmd_t;

  localparam int unsigned ReqAddrW = 13;

  localparam logic [7:0] PixMsb = 8'h80;
  localparam logic [7:0] White  = 8'hff;

endpackage

[rtl/core/fbde_ram.sv]
// fbde_ram: generic single-port ram with registered read
// no dependencies

module fbde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fbde_front.sv]
// fbde_front: accepts requests, clips and classifies them, queues commands
// depends on fbde_pkg

module fbde_front import fbde_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 200,
  parameter int unsigned SCREEN_HEIGHT = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        init_done_i,
  output logic        q_valid_o,
  output cmd_t        q_cmd_o,
  input  logic        q_pop_i
);

  localparam int unsigned RowBytes   = (SCREEN_WIDTH + 7) / 8;
  localparam int unsigned StoreBytes = RowBytes * SCREEN_HEIGHT;
  localparam logic [9:0]  ScrW       = 10'(SCREEN_WIDTH);
  localparam logic [9:0]  ScrH       = 10'(SCREEN_HEIGHT);
  localparam logic [13:0] StoreLim   = 14'(StoreBytes);
  localparam logic [1:0]  QDepth     = 2'd2;

  logic [7:0]  in_x, in_y, in_value;
  logic [8:0]  in_w, in_h;
  logic        in_color;
  logic [12:0] in_addr;
  logic [8:0]  ew, eh;
  logic [9:0]  xsum, ysum;
  logic [8:0]  xe, ye;
  logic        empty_rect, addr_ok, keep, push;
  cmd_t        cmd;

  cmd_t        fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;

  assign in_x     = s_axis_tdata_i[7:0];
  assign in_y     = s_axis_tdata_i[15:8];
  assign in_w     = s_axis_tdata_i[24:16];
  assign in_h     = s_axis_tdata_i[33:25];
  assign in_color = s_axis_tdata_i[34];
  assign in_addr  = s_axis_tdata_i[47:35];
  assign in_value = s_axis_tdata_i[55:48];

  always_comb begin
    // a plot is a one-by-one fill
    ew = in_w;
    eh = in_h;
    if (req_type_e'(s_axis_tuser_i) == REQ_PLOT) begin
      ew = 9'd1;
      eh = 9'd1;
    end
    xsum = {2'b00, in_x} + {1'b0, ew};
    ysum = {2'b00, in_y} + {1'b0, eh};
    xe   = (xsum > ScrW) ? ScrW[8:0] : xsum[8:0];
    ye   = (ysum > ScrH) ? ScrH[8:0] : ysum[8:0];
    empty_rect = ({1'b0, in_x} >= xe) || ({1'b0, in_y} >= ye);
    addr_ok    = {1'b0, in_addr} < StoreLim;

    cmd.x     = in_x;
    cmd.y     = in_y;
    cmd.xe    = xe;
    cmd.ye    = ye;
    cmd.color = in_color;
    cmd.addr  = in_addr;
    cmd.value = in_value;
    cmd.kind  = CMD_FILL;
    keep      = 1'b0;
    case (req_type_e'(s_axis_tuser_i))
      REQ_PLOT, REQ_FILL: begin
        cmd.kind = CMD_FILL;
        keep     = !empty_rect;
      end
      REQ_WRITE: begin
        cmd.kind = CMD_WRITE;
        keep     = addr_ok;
      end
      REQ_READ: begin
        cmd.kind = addr_ok ? CMD_READ : CMD_READ_ZERO;
        keep     = 1'b1;
      end
      default: begin
        cmd.kind = CMD_FILL;
        keep     = 1'b0;
      end
    endcase
  end

  assign s_axis_tready_o = init_done_i && (cnt_q != QDepth);
  assign push            = s_axis_tvalid_i && s_axis_tready_o && keep;
  assign cnt_d           = cnt_q + 2'(push) - 2'(q_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = fifo_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QDepth)
    else $error("command queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> (cnt_q != 2'd0))
    else $error("pop from empty command queue");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done_i |-> !s_axis_tready_o)
    else $error("request taken during clearing pass");

endmodule

[rtl/core/fbde_back.sv]
// fbde_back: carries out queued commands on the frame store, read-modify-write
// per pixel, clearing pass after reset; depends on fbde_pkg and fbde_ram

module fbde_back import fbde_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 200,
  parameter int unsigned SCREEN_HEIGHT = 200
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       init_done_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o
);

  localparam int unsigned RowBytes   = (SCREEN_WIDTH + 7) / 8;
  localparam int unsigned StoreBytes = RowBytes * SCREEN_HEIGHT;
  localparam int unsigned AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRD,
    ST_FWR,
    ST_RDATA
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] clr_q;
  logic [7:0]       cur_x_q, cur_y_q, x0_q;
  logic [8:0]       xe_q, ye_q;
  logic             color_q;
  logic             m_valid_q;
  logic [7:0]       out_q;

  logic             out_free, is_read, zero_pop;
  logic [13:0]      pix_addr;
  logic [7:0]       pix_mask;
  logic [8:0]       x_nxt, y_nxt;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign is_read  = q_cmd_i.kind inside {CMD_READ, CMD_READ_ZERO};
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i && (!is_read || out_free);
  assign zero_pop = q_pop_o && (q_cmd_i.kind == CMD_READ_ZERO);

  assign pix_addr = 14'({6'b0, cur_y_q} * 14'(RowBytes)) + 14'(cur_x_q[7:3]);
  assign pix_mask = PixMsb >> cur_x_q[2:0];
  assign x_nxt    = {1'b0, cur_x_q} + 9'd1;
  assign y_nxt    = {1'b0, cur_y_q} + 9'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pix_addr[AddrW-1:0];
    ram_wdata = q_cmd_i.value;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = White;
      end
      ST_IDLE: begin
        ram_addr = q_cmd_i.addr[AddrW-1:0];
        ram_we   = q_pop_o && (q_cmd_i.kind == CMD_WRITE);
      end
      ST_FWR: begin
        ram_we    = 1'b1;
        ram_wdata = color_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fbde_ram #(
    .WIDTH (8),
    .DEPTH (StoreBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      out_q     <= 8'd0;
    end else begin
      // a new result is loaded only once the previous one has left
      if ((state_q == ST_RDATA) || zero_pop) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (state_q == ST_RDATA) begin
        out_q <= ram_rdata;
      end else if (zero_pop) begin
        out_q <= 8'd0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == LastAddr) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_pop_o) begin
            case (q_cmd_i.kind)
              CMD_FILL: state_q <= ST_FRD;
              CMD_READ: state_q <= ST_RDATA;
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_FRD: state_q <= ST_FWR;
        ST_FWR: begin
          // walk the clipped rectangle row by row
          if (x_nxt < xe_q) begin
            state_q <= ST_FRD;
          end else if (y_nxt < ye_q) begin
            state_q <= ST_FRD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_RDATA: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_x_q <= q_cmd_i.x;
      cur_y_q <= q_cmd_i.y;
      x0_q    <= q_cmd_i.x;
      xe_q    <= q_cmd_i.xe;
      ye_q    <= q_cmd_i.ye;
      color_q <= q_cmd_i.color;
    end
    if (state_q == ST_FWR) begin
      if (x_nxt < xe_q) begin
        cur_x_q <= cur_x_q + 8'd1;
      end else begin
        cur_x_q <= x0_q;
        cur_y_q <= cur_y_q + 8'd1;
      end
    end
  end

  assign init_done_o     = (state_q != ST_CLEAR);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FWR) |-> ($past(state_q) == ST_FRD))
    else $error("pixel write without preceding read");

  a_rdata_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDATA) |=> m_valid_q)
    else $error("read result not presented");

  a_no_wr_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDATA || state_q == ST_FRD) |-> !ram_we)
    else $error("store written during a read cycle");

endmodule

[rtl/core/mono_framebuffer_draw_engine_top.sv]
// mono_framebuffer_draw_engine_top: 1bpp frame store draw engine, top level
// depends on fbde_pkg, fbde_front, fbde_back (which holds fbde_ram)
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_axis  | in  | x, y, rect_width, rect_height, color, byte_addr,    | req_type
//          |     | byte_value                                         |
//  m_axis  | out | read_data                                          | -
//
// after reset a clearing pass writes white to all ceil(SCREEN_WIDTH/8)*SCREEN_HEIGHT store
// bytes (5000 by default), one byte a cycle; no request is taken then
// the front takes one request a cycle while its two-entry command queue is not full
// the back issues each command from idle; a plot or fill then reads and writes back
// the store byte of each clipped pixel in turn, a raw write is done as it is issued,
// a read inside the store passes through a read-data state and one beyond it returns zero
// a waiting read result stalls only a read at the head of the queue and what is queued behind it

module mono_framebuffer_draw_engine_top import fbde_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = 200,
  parameter int unsigned SCREEN_HEIGHT = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,   // x, y, rect_width, rect_height, color, byte_addr, byte_value
  input  logic [1:0]  s_axis_tuser_i,   // req_type
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // read_data
);

  logic q_valid, q_pop, init_done;
  cmd_t q_cmd;

  fbde_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .init_done_i     (init_done),
    .q_valid_o       (q_valid),
    .q_cmd_o         (q_cmd),
    .q_pop_i         (q_pop)
  );

  fbde_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (q_cmd),
    .q_pop_o         (q_pop),
    .init_done_o     (init_done),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

[tb/tb.sv]
// tb: self-checking testbench for mono_framebuffer_draw_engine_top
// drives plot, fill, raw write and read transactions and checks every read result against
// a typed expectation or a local 1bpp frame store model; depends on fbde_pkg and the rtl top
`timescale 1ns / 100ps

module tb;
  import fbde_pkg::*;

  localparam int unsigned SCR_W        = 200;
  localparam int unsigned SCR_H        = 200;
  localparam int unsigned ROW_BYTES    = (SCR_W + 7) / 8;
  localparam int unsigned STORE_BYTES  = ROW_BYTES * SCR_H;
  localparam int unsigned ADDR_MAX     = (1 << ReqAddrW) - 1;
  localparam int unsigned RAND_ITEMS   = 430;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam longint      LIMIT_CYCLES = 3_000_000;

  typedef struct {
    req_type_e   kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic        color;
    logic [12:0] addr;
    logic [7:0]  value;
    bit          chk;       // typed expectation below is used
    logic [7:0]  exp_data;
  } draw_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;   // x, y, rect_width, rect_height, color, byte_addr, byte_value
  logic [1:0]  s_axis_tuser_i;   // req_type
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // read_data

  logic [7:0]  fb_model [STORE_BYTES];
  logic [7:0]  read_expect_q [$];
  draw_req_t   directed_tbl [$];
  int unsigned hot_addr;
  int unsigned mismatches = 0;
  int unsigned reads_checked = 0;
  int unsigned reqs_sent;
  int          tx_calm;
  int          rx_calm;
  longint      cycles = 0;

  mono_framebuffer_draw_engine_top #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: timeout after %0d cycles, %0d reads pending", cycles, read_expect_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    mismatches++;
    $display("tb: mismatch, %s: expected %02h got %02h at cycle %0d", what, want, got, cycles);
  endtask

  // mostly short gaps, a few long ones, and calm stretches without any
  function automatic int pick_gap(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void plot_px(int unsigned px, int unsigned py, logic c);
    int unsigned a;
    logic [7:0]  mask;
    if (px >= SCR_W || py >= SCR_H) return;
    a = (px >> 3) + py * ROW_BYTES;
    if (a >= STORE_BYTES) return;
    mask = PixMsb >> (px & 7);
    if (c) fb_model[13'(a)] = fb_model[13'(a)] | mask;
    else   fb_model[13'(a)] = fb_model[13'(a)] & ~mask;
    hot_addr = a;
  endfunction

  function automatic void predict_request(input draw_req_t r, output bit has_data,
                                          output logic [7:0] data);
    int unsigned xe;
    int unsigned ye;
    has_data = 1'b0;
    data     = 8'h00;
    case (r.kind)
      REQ_PLOT: plot_px(r.x, r.y, r.color);
      REQ_FILL: begin
        xe = r.x + r.w;
        ye = r.y + r.h;
        if (xe > SCR_W) xe = SCR_W;
        if (ye > SCR_H) ye = SCR_H;
        for (int unsigned j = r.y; j < ye; j++)
          for (int unsigned i = r.x; i < xe; i++)
            plot_px(i, j, r.color);
      end
      REQ_WRITE: begin
        if (r.addr < STORE_BYTES) begin
          fb_model[r.addr] = r.value;
          hot_addr = r.addr;
        end
      end
      default: begin
        has_data = 1'b1;
        data     = (r.addr < STORE_BYTES) ? fb_model[r.addr] : 8'h00;
      end
    endcase
  endfunction

  function automatic draw_req_t dreq(req_type_e kind, int x, int y, int w, int h, bit color,
                                     int addr, int value, bit chk, logic [7:0] exp_data);
    draw_req_t r;
    r.kind     = kind;
    r.x        = 8'(x);
    r.y        = 8'(y);
    r.w        = 9'(w);
    r.h        = 9'(h);
    r.color    = color;
    r.addr     = 13'(addr);
    r.value    = 8'(value);
    r.chk      = chk;
    r.exp_data = exp_data;
    return r;
  endfunction

  function automatic draw_req_t rand_req();
    draw_req_t r;
    int        pick;
    // unused fields carry random junk
    r.x        = 8'($urandom_range(0, 255));
    r.y        = 8'($urandom_range(0, 255));
    r.w        = 9'($urandom_range(0, 256));
    r.h        = 9'($urandom_range(0, 256));
    r.color    = 1'($urandom_range(0, 1));
    r.addr     = 13'($urandom_range(0, ADDR_MAX));
    r.value    = 8'($urandom_range(0, 255));
    r.chk      = 1'b0;
    r.exp_data = 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.kind = REQ_PLOT;
      if ($urandom_range(0, 99) < 85) begin
        r.x = 8'($urandom_range(0, SCR_W - 1));
        r.y = 8'($urandom_range(0, SCR_H - 1));
      end
    end else if (pick < 45) begin
      r.kind = REQ_FILL;
      if ($urandom_range(0, 9) != 0) begin
        r.x = 8'($urandom_range(0, SCR_W - 1));
        r.y = 8'($urandom_range(0, SCR_H - 1));
      end
      // keep fills cheap except now and then
      if ($urandom_range(0, 99) >= 4) begin
        r.w = 9'($urandom_range(0, 12));
        r.h = 9'($urandom_range(0, 12));
      end
    end else if (pick < 70) begin
      r.kind = REQ_WRITE;
      if ($urandom_range(0, 99) < 93) r.addr = 13'($urandom_range(0, STORE_BYTES - 1));
      else                            r.addr = 13'($urandom_range(STORE_BYTES, ADDR_MAX));
    end else begin
      r.kind = REQ_READ;
      pick = $urandom_range(0, 9);
      if (pick < 5)      r.addr = 13'(hot_addr);
      else if (pick < 9) r.addr = 13'($urandom_range(0, STORE_BYTES - 1));
      else               r.addr = 13'($urandom_range(STORE_BYTES, ADDR_MAX));
    end
    return r;
  endfunction

  // caller stands just after a rising edge; returns right after the accepting edge
  task automatic send_req(draw_req_t r);
    int         gap;
    bit         has_data;
    logic [7:0] data;
    gap = pick_gap(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  <= {r.value, r.addr, r.color, r.h, r.w, r.y, r.x};
    s_axis_tuser_i  <= r.kind;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_request(r, has_data, data);
    if (has_data) read_expect_q.push_back(r.chk ? r.exp_data : data);
    reqs_sent++;
  endtask

  // read result check
  always @(posedge clk_i) begin : result_check
    logic [7:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      reads_checked++;
      if (read_expect_q.size() == 0) begin
        report_mismatch("read result with no read pending", 8'h00, m_axis_tdata_o);
      end else begin
        want = read_expect_q.pop_front();
        if (m_axis_tdata_o !== want) report_mismatch("read_data", want, m_axis_tdata_o);
      end
    end
  end

  // result receiver, with one long hold-off once traffic is going
  initial begin : result_sink
    int  stall_left;
    bit  held;
    m_axis_tready_i = 1'b0;
    stall_left      = 0;
    held            = 1'b0;
    rx_calm         = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!held && reads_checked >= 40) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  initial begin : stimulus
    int unsigned n_directed;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = REQ_PLOT;
    rst_ni          = 1'b0;
    reqs_sent       = 0;
    tx_calm         = 0;
    hot_addr        = 0;
    for (int i = 0; i < STORE_BYTES; i++) fb_model[13'(i)] = White;

    // store starts white; out-of-range reads give zero and writes there are dropped
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0,    0,    0, 1, 8'hff));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0, 4999,    0, 1, 8'hff));
    directed_tbl.push_back(dreq(REQ_READ,  255, 255, 256, 256, 1, 8191,  255, 1, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0, 5000,    0, 1, 8'h00));
    directed_tbl.push_back(dreq(REQ_WRITE,   0,   0,   0,   0, 0, 8191, 8'h00, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0, 8191,    0, 1, 8'h00));
    directed_tbl.push_back(dreq(REQ_WRITE,   0,   0,   0,   0, 0, 4999, 8'ha5, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0, 4999,    0, 1, 8'ha5));
    directed_tbl.push_back(dreq(REQ_WRITE,   0,   0,   0,   0, 0,    0, 8'h00, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0,    0,    0, 1, 8'h00));
    directed_tbl.push_back(dreq(REQ_PLOT,    0,   0,   0,   0, 1,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0,    0,    0, 1, 8'h80));
    directed_tbl.push_back(dreq(REQ_PLOT,  199, 199,   0,   0, 0,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0, 4999,    0, 1, 8'ha4));
    // off-screen pixels are ignored
    directed_tbl.push_back(dreq(REQ_PLOT,  200,   0,   0,   0, 0,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_PLOT,  255, 255,   0,   0, 0,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_PLOT,    0, 200,   0,   0, 0,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0,   25,    0, 1, 8'hff));
    // full clipped fill to black, then a corner fill past both edges
    directed_tbl.push_back(dreq(REQ_FILL,    0,   0, 256, 256, 0,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0,    0,    0, 1, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0, 4999,    0, 1, 8'h00));
    directed_tbl.push_back(dreq(REQ_FILL,  196, 196, 256, 256, 1,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0, 4999,    0, 1, 8'h0f));
    // zero-sized fills draw nothing
    directed_tbl.push_back(dreq(REQ_FILL,   10,  10,   0,   5, 1,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_FILL,   10,  10,   5,   0, 1,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0,  251,    0, 1, 8'h00));
    directed_tbl.push_back(dreq(REQ_FILL,    3,   2,   9,   2, 1,    0,    0, 0, 8'h00));
    directed_tbl.push_back(dreq(REQ_READ,    0,   0,   0,   0, 0,   50,    0, 0, 8'h00));
    n_directed = directed_tbl.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[i]) send_req(directed_tbl[i]);

    for (int unsigned k = 0; k < RAND_ITEMS; k++) begin
      // one pause with the input idle until all reads are back
      if (k == RAND_ITEMS / 2) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        while (read_expect_q.size() != 0) @(posedge clk_i);
      end
      send_req(rand_req());
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    while (read_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (read_expect_q.size() != 0)
      report_mismatch("read results still pending at end", 8'h00, 8'h00);

    $display("tb: %0d requests sent (%0d directed), %0d read results checked, %0d mismatches",
             reqs_sent, n_directed, reads_checked, mismatches);
    $display("tb: plots, clipped fills, raw writes and reads incl. out-of-range addresses");
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fbde_pkg.sv
rtl/core/fbde_ram.sv
rtl/core/fbde_front.sv
rtl/core/fbde_back.sv
rtl/core/mono_framebuffer_draw_engine_top.sv
tb/tb.sv
